// File: rtl/cdt_pkg.sv
// Shared constants, register indexes and helpers of the chessboard distance transform.
`default_nettype none

package cdt_pkg;

    localparam int DIM_W     = 9;
    localparam int PIX_W     = 8;
    localparam int DIST_W    = 9;
    localparam int ACC_W     = DIST_W + 1;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 256;

    localparam logic [DIM_W-1:0]  DIM_RESET = 9'd256;
    localparam logic [DIST_W-1:0] DIST_MAX  = 9'd511;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'b1;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    // A zero dimension acts as one; anything above the maximum acts as the maximum.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v, input int maxv);
        logic [DIM_W-1:0] r;
        begin
            r = v;
            if (v == '0)
                r = DIM_W'(1);
            else if (int'(v) > maxv)
                r = DIM_W'(maxv);
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/chessboard_distance_transform_core.sv
// Chessboard distance transform core: pixel loading, two-pass transform and readout.
// A load item is taken every cycle while the core is idle; the pixel that completes the frame
// starts the transform, which visits every pixel twice: a background pixel takes only a center
// read, an object pixel a center and four neighbor reads through the single read port, then a write.
// A fetch result is registered in ST_RESP once the output is free; the next item is taken back in ST_IDLE.
// Reset clears control state and sets both dimensions to 256; frame store contents stay undefined.
`default_nettype none

module chessboard_distance_transform_core #(
    parameter int MAX_ROWS = cdt_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = cdt_pkg::DEF_MAX_COLS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           req_type,
    input  wire logic [cdt_pkg::PIX_W-1:0]      pixel,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [cdt_pkg::DIST_W-1:0]     distance,
    output logic                                last_pixel,
    output logic                                empty_res,
    input  wire logic                           cfg_we,
    input  wire logic [cdt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cdt_pkg::DIM_W-1:0]      cfg_data
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = ((ADDR_W > cdt_pkg::DIM_W) ? ADDR_W : cdt_pkg::DIM_W) + 1;
    localparam int DIM_W  = cdt_pkg::DIM_W;
    localparam int DIST_W = cdt_pkg::DIST_W;
    localparam int ACC_W  = cdt_pkg::ACC_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RESP = 3'd1;
    localparam logic [2:0] ST_CTR  = 3'd2;
    localparam logic [2:0] ST_NB   = 3'd3;
    localparam logic [2:0] ST_LAST = 3'd4;
    localparam logic [2:0] ST_WR   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic              fwd_reg, fwd_next;
    logic [1:0]        k_reg, k_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              oob_reg, oob_next;
    logic [DIM_W-1:0]  row_reg, row_next;
    logic [DIM_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              ready_reg, ready_next;
    logic [DIM_W-1:0]  rows_cfg_reg, rows_cfg_next;
    logic [DIM_W-1:0]  cols_cfg_reg, cols_cfg_next;
    logic              resp_empty_reg, resp_empty_next;
    logic              resp_last_reg, resp_last_next;
    logic              out_valid_reg, out_valid_next;
    logic [DIST_W-1:0] distance_reg, distance_next;
    logic              last_reg, last_next;
    logic              empty_reg, empty_next;

    logic [DIM_W-1:0]  rows_m1, cols_m1;
    logic              in_acc, base_zero, base_last, at_first, adv;
    logic [DIM_W-1:0]  base_row, base_col, inc_row, inc_col, dec_row, dec_col;
    logic [ADDR_W-1:0] base_addr;
    logic              nb_up, nb_down, nb_left, nb_right, nb_oob;
    logic [SUM_W-1:0]  nb_sum;
    logic [ADDR_W-1:0] nb_addr;
    logic [DIST_W-1:0] nb_val;
    logic [ACC_W-1:0]  cand;
    logic [DIST_W-1:0] sat_val;
    logic              out_free;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [DIST_W-1:0] ram_wdata, ram_rdata;

    cdt_frame_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (DIST_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rows_m1 = cdt_pkg::eff_dim(rows_cfg_reg, MAX_ROWS) - DIM_W'(1);
    assign cols_m1 = cdt_pkg::eff_dim(cols_cfg_reg, MAX_COLS) - DIM_W'(1);

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_acc     = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign distance   = distance_reg;
    assign last_pixel = last_reg;
    assign empty_res  = empty_reg;
    assign out_free   = !out_valid_reg || !out_stall;

    // A load onto a finished frame drops it and restarts the cursor at the first pixel.
    assign base_zero = (state_reg == ST_IDLE) && (req_type == cdt_pkg::REQ_LOAD) && ready_reg;
    assign base_row  = base_zero ? '0 : row_reg;
    assign base_col  = base_zero ? '0 : col_reg;
    assign base_addr = base_zero ? '0 : addr_reg;
    assign base_last = (base_row == rows_m1) && (base_col == cols_m1);
    assign at_first  = (row_reg == '0) && (col_reg == '0);

    assign inc_col = (base_col == cols_m1) ? '0 : base_col + DIM_W'(1);
    assign inc_row = (base_col == cols_m1) ? base_row + DIM_W'(1) : base_row;
    assign dec_col = (col_reg == '0) ? cols_m1 : col_reg - DIM_W'(1);
    assign dec_row = (col_reg == '0) ? row_reg - DIM_W'(1) : row_reg;

    // Neighbor k of the current pass: forward takes upper-left, upper, upper-right, left;
    // backward takes right, lower-left, lower, lower-right.
    assign nb_up    = fwd_reg && (k_reg != 2'd3);
    assign nb_down  = !fwd_reg && (k_reg != 2'd0);
    assign nb_left  = fwd_reg ? (k_reg == 2'd0 || k_reg == 2'd3) : (k_reg == 2'd1);
    assign nb_right = fwd_reg ? (k_reg == 2'd2) : (k_reg == 2'd0 || k_reg == 2'd3);
    assign nb_oob   = (nb_up && row_reg == '0) || (nb_down && row_reg == rows_m1)
                   || (nb_left && col_reg == '0) || (nb_right && col_reg == cols_m1);

    always_comb
    begin
        nb_sum = SUM_W'(addr_reg);
        if (nb_up)
            nb_sum = nb_sum - SUM_W'(cols_m1) - SUM_W'(1);
        else if (nb_down)
            nb_sum = nb_sum + SUM_W'(cols_m1) + SUM_W'(1);
        if (nb_left)
            nb_sum = nb_sum - SUM_W'(1);
        else if (nb_right)
            nb_sum = nb_sum + SUM_W'(1);
    end
    assign nb_addr = nb_sum[ADDR_W-1:0];

    assign nb_val  = oob_reg ? '0 : ram_rdata;
    assign cand    = {1'b0, nb_val} + ACC_W'(1);
    assign sat_val = (acc_reg > {1'b0, cdt_pkg::DIST_MAX}) ? cdt_pkg::DIST_MAX
                                                           : acc_reg[DIST_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        fwd_next        = fwd_reg;
        k_next          = k_reg;
        acc_next        = acc_reg;
        oob_next        = oob_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        addr_next       = addr_reg;
        ready_next      = ready_reg;
        rows_cfg_next   = rows_cfg_reg;
        cols_cfg_next   = cols_cfg_reg;
        resp_empty_next = resp_empty_reg;
        resp_last_next  = resp_last_reg;
        out_valid_next  = out_valid_reg && out_stall;
        distance_next   = distance_reg;
        last_next       = last_reg;
        empty_next      = empty_reg;
        ram_we          = 1'b0;
        ram_waddr       = addr_reg;
        ram_wdata       = sat_val;
        ram_re          = 1'b0;
        ram_raddr       = addr_reg;
        adv             = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && req_type == cdt_pkg::REQ_LOAD)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = base_addr;
                    ram_wdata  = (pixel != '0) ? DIST_W'(1) : '0;
                    ready_next = 1'b0;
                    if (base_last)
                    begin
                        row_next   = '0;
                        col_next   = '0;
                        addr_next  = '0;
                        fwd_next   = 1'b1;
                        state_next = ST_CTR;
                    end
                    else
                    begin
                        row_next  = inc_row;
                        col_next  = inc_col;
                        addr_next = base_addr + ADDR_W'(1);
                    end
                end
                else if (in_acc)
                begin
                    state_next      = ST_RESP;
                    resp_empty_next = !ready_reg;
                    resp_last_next  = ready_reg && base_last;
                    if (ready_reg)
                    begin
                        ram_re = 1'b1;
                        if (base_last)
                        begin
                            ready_next = 1'b0;
                            row_next   = '0;
                            col_next   = '0;
                            addr_next  = '0;
                        end
                        else
                        begin
                            row_next  = inc_row;
                            col_next  = inc_col;
                            addr_next = addr_reg + ADDR_W'(1);
                        end
                    end
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    distance_next  = resp_empty_reg ? '0 : ram_rdata;
                    last_next      = resp_last_reg;
                    empty_next     = resp_empty_reg;
                    state_next     = ST_IDLE;
                end
            end

            ST_CTR:
            begin
                ram_re     = 1'b1;
                k_next     = 2'd0;
                state_next = ST_NB;
            end

            ST_NB:
            begin
                ram_re    = 1'b1;
                ram_raddr = nb_addr;
                oob_next  = nb_oob;
                if (k_reg == 2'd0)
                begin
                    // The center value arrives now; background pixels are left as they are.
                    if (ram_rdata == '0)
                        adv = 1'b1;
                    else
                        acc_next = fwd_reg ? '1 : {1'b0, ram_rdata};
                end
                else if (cand < acc_reg)
                begin
                    acc_next = cand;
                end
                if (!(k_reg == 2'd0 && ram_rdata == '0))
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = (k_reg == 2'd3) ? ST_LAST : ST_NB;
                end
            end

            ST_LAST:
            begin
                if (cand < acc_reg)
                    acc_next = cand;
                state_next = ST_WR;
            end

            ST_WR:
            begin
                ram_we = 1'b1;
                adv    = 1'b1;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (adv)
        begin
            state_next = ST_CTR;
            if (fwd_reg)
            begin
                // The backward pass starts on the pixel where the forward pass ends.
                if (base_last)
                begin
                    fwd_next = 1'b0;
                end
                else
                begin
                    row_next  = inc_row;
                    col_next  = inc_col;
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end
            else if (at_first)
            begin
                ready_next = 1'b1;
                state_next = ST_IDLE;
            end
            else
            begin
                row_next  = dec_row;
                col_next  = dec_col;
                addr_next = addr_reg - ADDR_W'(1);
            end
        end

        if (cfg_we && (cfg_index == cdt_pkg::REG_FRAME_ROWS || cfg_index == cdt_pkg::REG_FRAME_COLS))
        begin
            if (cfg_index == cdt_pkg::REG_FRAME_ROWS)
                rows_cfg_next = cfg_data;
            else
                cols_cfg_next = cfg_data;
            row_next   = '0;
            col_next   = '0;
            addr_next  = '0;
            ready_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fwd_reg       <= 1'b1;
            k_reg         <= 2'd0;
            row_reg       <= '0;
            col_reg       <= '0;
            addr_reg      <= '0;
            ready_reg     <= 1'b0;
            rows_cfg_reg  <= cdt_pkg::DIM_RESET;
            cols_cfg_reg  <= cdt_pkg::DIM_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fwd_reg       <= fwd_next;
            k_reg         <= k_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            addr_reg      <= addr_next;
            ready_reg     <= ready_next;
            rows_cfg_reg  <= rows_cfg_next;
            cols_cfg_reg  <= cols_cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg        <= acc_next;
        oob_reg        <= oob_next;
        resp_empty_reg <= resp_empty_next;
        resp_last_reg  <= resp_last_next;
        distance_reg   <= distance_next;
        last_reg       <= last_next;
        empty_reg      <= empty_next;
    end

endmodule

`default_nettype wire

// File: rtl/cdt_frame_ram.sv
// Frame store: one write port and one registered read port with read enable.
`default_nettype none

module cdt_frame_ram #(
    parameter int DEPTH  = cdt_pkg::DEF_MAX_ROWS * cdt_pkg::DEF_MAX_COLS,
    parameter int ADDR_W = 16,
    parameter int DATA_W = cdt_pkg::DIST_W
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
